// ===== rtl/pfba_pkg.sv =====
// ----------------------------------------------------------------------------
// pfba_pkg: shared definitions for the physical frame bitmap allocator
// Status codes, result kinds, controller/datapath handshake structs and the
// lowest-clear-bit encoder used by the allocate path.
// ----------------------------------------------------------------------------
package pfba_pkg;

  localparam int          MAX_FRAMES_DEF  = 32768;
  localparam int          FRAME_W         = 15;
  localparam int          CFG_W           = 16;
  localparam int          STATUS_W        = 2;
  localparam int          WORD_W          = 32;
  localparam int          BIT_W           = 5;
  localparam int          FRAME_FIELD_LIM = 32768;
  localparam logic [31:0] FULL_WORD       = 32'hFFFF_FFFF;
  localparam logic [15:0] CFG_RESET       = 16'd32768;

  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOACT = 2'd1;
  localparam logic [STATUS_W-1:0] ST_OOF   = 2'd2;

  // What kind of result the datapath assembles when it loads the output.
  typedef enum logic [1:0] {
    RK_ALLOC = 2'd0,
    RK_NOACT = 2'd1,
    RK_OOF   = 2'd2,
    RK_FREED = 2'd3
  } res_kind_t;

  typedef struct packed {
    logic      in_rdy;
    logic      clr_wr;
    logic      cnt_clr;
    logic      cnt_inc;
    logic      scan_rd;
    logic      cap_word;
    logic      enc_wr;
    logic      free_rd;
    logic      free_wr;
    logic      load_out;
    res_kind_t kind;
  } ctrl_cmd_t;

  typedef struct packed {
    logic accept;
    logic noact;
    logic is_free;
    logic free_managed;
    logic hit;
    logic scan_end;
    logic rd_pending;
    logic out_free;
    logic clr_last;
  } dp_stat_t;

  // Index of the lowest clear bit of a word that is known not to be full.
  // Binary search over halves: five narrow steps.
  function automatic logic [BIT_W-1:0] lowest_clear(input logic [WORD_W-1:0] word);
    logic [WORD_W-1:0] v;
    logic [BIT_W-1:0]  idx;
    logic [WORD_W-1:0] mask;
    v   = ~word;
    idx = '0;
    for (int i = BIT_W - 1; i >= 0; i--) begin
      mask = (32'd1 << (1 << i)) - 32'd1;
      if ((v & mask) == '0) begin
        idx[i] = 1'b1;
        v      = v >> (1 << i);
      end
    end
    return idx;
  endfunction

endpackage

// ===== rtl/pfba_if.sv =====
// ----------------------------------------------------------------------------
// pfba_if: request and result channels of the frame allocator
// Valid/ready channels; a transaction moves when valid and ready are high.
// ----------------------------------------------------------------------------
interface pfba_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [14:0] current_frame;
  logic        kernel_mode;
  logic        writable;

  modport source (output valid, output func, output current_frame,
                  output kernel_mode, output writable, input ready);
  modport sink   (input valid, input func, input current_frame,
                  input kernel_mode, input writable, output ready);
endinterface

interface pfba_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic        entry_present;
  logic        entry_write;
  logic        entry_user;
  logic [14:0] entry_frame;

  modport source (output valid, output status, output entry_present,
                  output entry_write, output entry_user, output entry_frame,
                  input ready);
  modport sink   (input valid, input status, input entry_present,
                  input entry_write, input entry_user, input entry_frame,
                  output ready);
endinterface

// ===== rtl/pfba_ram.sv =====
// ----------------------------------------------------------------------------
// pfba_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module pfba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/pfba_ctrl.sv =====
// ----------------------------------------------------------------------------
// pfba_ctrl: sequencer of the frame allocator
// Clears the bitmap after reset, then runs one transaction at a time.
// ----------------------------------------------------------------------------
module pfba_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  pfba_pkg::dp_stat_t   stat,
  output pfba_pkg::ctrl_cmd_t  cmd
);
  import pfba_pkg::*;

  typedef enum logic [6:0] {
    S_CLR     = 7'b0000001,
    S_IDLE    = 7'b0000010,
    S_SCAN    = 7'b0000100,
    S_ENC     = 7'b0001000,
    S_FREE_RD = 7'b0010000,
    S_FREE_WR = 7'b0100000,
    S_DONE    = 7'b1000000
  } state_t;

  state_t    state_r, state_nxt;
  res_kind_t kind_r, kind_nxt;

  always_comb begin
    state_nxt = state_r;
    kind_nxt  = kind_r;
    cmd       = '0;
    cmd.kind  = kind_r;
    case (state_r)
      S_CLR: begin
        cmd.clr_wr  = 1'b1;
        cmd.cnt_inc = 1'b1;
        if (stat.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        cmd.in_rdy  = 1'b1;
        cmd.cnt_clr = 1'b1;
        if (stat.accept) begin
          if (stat.noact) begin
            kind_nxt  = RK_NOACT;
            state_nxt = S_DONE;
          end else if (stat.is_free) begin
            kind_nxt  = RK_FREED;
            state_nxt = stat.free_managed ? S_FREE_RD : S_DONE;
          end else begin
            kind_nxt  = RK_ALLOC;
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (stat.hit) begin
          cmd.cap_word = 1'b1;
          state_nxt    = S_ENC;
        end else if (stat.scan_end) begin
          if (!stat.rd_pending) begin
            kind_nxt  = RK_OOF;
            state_nxt = S_DONE;
          end
        end else begin
          cmd.scan_rd = 1'b1;
          cmd.cnt_inc = 1'b1;
        end
      end
      S_ENC: begin
        cmd.enc_wr = 1'b1;
        state_nxt  = S_DONE;
      end
      S_FREE_RD: begin
        cmd.free_rd = 1'b1;
        state_nxt   = S_FREE_WR;
      end
      S_FREE_WR: begin
        cmd.free_wr = 1'b1;
        state_nxt   = S_DONE;
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      kind_r  <= RK_NOACT;
    end else begin
      state_r <= state_nxt;
      kind_r  <= kind_nxt;
    end
  end

endmodule

// ===== rtl/pfba_dp.sv =====
// ----------------------------------------------------------------------------
// pfba_dp: datapath of the frame allocator
// Bitmap RAM, word counter, scan pipeline, encoder and result register.
// ----------------------------------------------------------------------------
module pfba_dp #(
  parameter int MAX_FRAMES = pfba_pkg::MAX_FRAMES_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  pfba_in_if.sink                    in_chan,
  pfba_out_if.source                 out_chan,
  input  logic                       cfg_we,
  input  logic [pfba_pkg::CFG_W-1:0] cfg_wdata,
  input  pfba_pkg::ctrl_cmd_t        cmd,
  output pfba_pkg::dp_stat_t         stat
);
  import pfba_pkg::*;

  localparam int WORD_COUNT = (MAX_FRAMES + WORD_W - 1) / WORD_W;
  localparam int WIDX_W     = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
  localparam int CNT_W      = $clog2(WORD_COUNT + 1);
  localparam int LIM_CAP    = (MAX_FRAMES < FRAME_FIELD_LIM) ? MAX_FRAMES : FRAME_FIELD_LIM;

  logic [CFG_W-1:0]   cfg_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [FRAME_W-1:0] cur_r;
  logic               kern_r, wr_r;
  logic               rvalid_r;
  logic [WIDX_W-1:0]  raddr_r, widx_r;
  logic [WORD_W-1:0]  word_r;
  logic [BIT_W-1:0]   bit_r;

  logic               out_valid_r;
  logic [STATUS_W-1:0] out_status_r;
  logic               out_present_r, out_write_r, out_user_r;
  logic [FRAME_W-1:0] out_frame_r;

  logic [STATUS_W-1:0] out_status_nxt;
  logic               out_present_nxt, out_write_nxt, out_user_nxt;
  logic [FRAME_W-1:0] out_frame_nxt;

  // Scan limit: register value capped at the managed and representable
  // frame counts, in whole words.
  logic [20:0] lim;
  logic [11:0] words;
  always_comb begin
    lim = 21'(cfg_r);
    if (lim > 21'(LIM_CAP)) begin
      lim = 21'(LIM_CAP);
    end
    words = lim[16:5];
  end

  logic [20:0]       fwide;
  logic [WIDX_W-1:0] fidx;
  logic [WIDX_W-1:0] cnt_idx;
  assign fwide   = 21'(cur_r) >> BIT_W;
  assign fidx    = fwide[WIDX_W-1:0];
  assign cnt_idx = cnt_r[WIDX_W-1:0];

  // Bitmap memory.
  logic              ram_we, ram_re;
  logic [WIDX_W-1:0] ram_waddr, ram_raddr;
  logic [WORD_W-1:0] ram_wdata, ram_rdata;

  always_comb begin
    ram_we    = cmd.clr_wr | cmd.enc_wr | cmd.free_wr;
    ram_waddr = cnt_idx;
    ram_wdata = '0;
    if (cmd.enc_wr) begin
      ram_waddr = widx_r;
      ram_wdata = word_r | (~word_r & (word_r + 32'd1));
    end else if (cmd.free_wr) begin
      ram_waddr = fidx;
      ram_wdata = ram_rdata & ~(32'd1 << cur_r[BIT_W-1:0]);
    end
    ram_re    = cmd.scan_rd | cmd.free_rd;
    ram_raddr = cmd.free_rd ? fidx : cnt_idx;
  end

  pfba_ram #(
    .WIDTH (WORD_W),
    .DEPTH (WORD_COUNT),
    .AW    (WIDX_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Status toward the controller.
  assign in_chan.ready = cmd.in_rdy;
  always_comb begin
    stat.accept       = in_chan.valid & cmd.in_rdy;
    stat.is_free      = in_chan.func;
    stat.noact        = in_chan.func ? (in_chan.current_frame == '0)
                                     : (in_chan.current_frame != '0);
    stat.free_managed = 21'(in_chan.current_frame) < 21'(MAX_FRAMES);
    stat.hit          = rvalid_r & (ram_rdata != FULL_WORD);
    stat.scan_end     = 16'(cnt_r) == 16'(words);
    stat.rd_pending   = rvalid_r;
    stat.out_free     = ~out_valid_r | out_chan.ready;
    stat.clr_last     = cnt_r == CNT_W'(WORD_COUNT - 1);
  end

  logic [31:0] fr32;
  assign fr32 = (32'(widx_r) << BIT_W) | 32'(bit_r);

  // Result fields for the kind of transaction that finishes.
  always_comb begin
    out_status_nxt  = ST_DONE;
    out_present_nxt = 1'b0;
    out_write_nxt   = 1'b0;
    out_user_nxt    = 1'b0;
    out_frame_nxt   = '0;
    case (cmd.kind)
      RK_ALLOC: begin
        out_present_nxt = 1'b1;
        out_write_nxt   = wr_r;
        out_user_nxt    = ~kern_r;
        out_frame_nxt   = fr32[FRAME_W-1:0];
      end
      RK_NOACT: out_status_nxt = ST_NOACT;
      RK_OOF:   out_status_nxt = ST_OOF;
      default:  out_status_nxt = ST_DONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r       <= CFG_RESET;
      cnt_r       <= '0;
      rvalid_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        cfg_r <= cfg_wdata;
      end
      if (cmd.cnt_clr) begin
        cnt_r <= '0;
      end else if (cmd.cnt_inc) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end
      rvalid_r <= cmd.scan_rd;
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (stat.accept) begin
      cur_r  <= in_chan.current_frame;
      kern_r <= in_chan.kernel_mode;
      wr_r   <= in_chan.writable;
    end
    if (cmd.scan_rd) begin
      raddr_r <= cnt_idx;
    end
    if (cmd.cap_word) begin
      word_r <= ram_rdata;
      widx_r <= raddr_r;
    end
    if (cmd.enc_wr) begin
      bit_r <= lowest_clear(word_r);
    end
    if (cmd.load_out) begin
      out_status_r  <= out_status_nxt;
      out_present_r <= out_present_nxt;
      out_write_r   <= out_write_nxt;
      out_user_r    <= out_user_nxt;
      out_frame_r   <= out_frame_nxt;
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.status        = out_status_r;
  assign out_chan.entry_present = out_present_r;
  assign out_chan.entry_write   = out_write_r;
  assign out_chan.entry_user    = out_user_r;
  assign out_chan.entry_frame   = out_frame_r;

endmodule

// ===== rtl/physical_frame_bitmap_allocator.sv =====
// From accept to result valid: a no-action transaction or a free of an unmanaged frame
// goes straight to the result, a free reads and rewrites one bitmap word, and an allocate
// reads at most all scanned bitmap words (1024 at the default size), one a cycle.
// A new request is accepted once the previous result sits in the output register.
// Reset (rst_n low, synchronous) runs a clearing pass over all MAX_FRAMES/32 (rounded up)
// words of the bitmap RAM; no request is accepted during it.
// ----------------------------------------------------------------------------
// physical_frame_bitmap_allocator: first-fit physical frame allocator
// Keeps a one-bit-per-frame usage bitmap and allocates or frees frames for
// page entries, one transaction at a time.
// ----------------------------------------------------------------------------
module physical_frame_bitmap_allocator #(
  parameter int MAX_FRAMES = pfba_pkg::MAX_FRAMES_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  pfba_in_if.sink                    in_chan,
  pfba_out_if.source                 out_chan,
  input  logic                       cfg_we,
  input  logic [pfba_pkg::CFG_W-1:0] cfg_wdata
);
  import pfba_pkg::*;

  // The controller sequences each transaction: after accept it either goes
  // straight to the result (no action, or a free of an unmanaged frame),
  // does a read-modify-write of one bitmap word (free), or scans the words
  // one per cycle from word zero (allocate).
  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  pfba_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .cmd   (cmd)
  );

  // The datapath owns the bitmap RAM, the frame-count register and the
  // output register. Reads during a scan are pipelined: the word read in one
  // cycle is checked against all-ones in the next while the following read
  // is issued. The first word that is not full is captured, its lowest clear
  // bit is set and written back, and the frame number is built from the word
  // index and the bit position.
  pfba_dp #(
    .MAX_FRAMES (MAX_FRAMES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

// ===== rtl/pfba_checker.sv =====
// ----------------------------------------------------------------------------
// pfba_checker: port-level checks of the frame allocator
// Watches the top-level ports only; attached by the bind below.
// ----------------------------------------------------------------------------
module pfba_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  status,
  input logic        entry_present,
  input logic        entry_write,
  input logic        entry_user,
  input logic [14:0] entry_frame
);
  import pfba_pkg::*;

  // A result holds until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before it was taken");

  // Only one transaction is in flight: ready falls after every accept.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while another is in flight");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (status == ST_DONE || status == ST_NOACT || status == ST_OOF))
    else $error("undefined status code");

  // No-action and out-of-frames results carry an all-zero entry.
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status != ST_DONE |->
      !entry_present && !entry_write && !entry_user && entry_frame == '0)
    else $error("failed transaction returned a nonzero entry");

  // A not-present entry never carries a frame or permission bits.
  a_free_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !entry_present |-> entry_frame == '0 && !entry_write && !entry_user)
    else $error("not-present entry carries a frame");

endmodule

bind physical_frame_bitmap_allocator pfba_checker u_pfba_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_chan.valid),
  .in_ready      (in_chan.ready),
  .out_valid     (out_chan.valid),
  .out_ready     (out_chan.ready),
  .status        (out_chan.status),
  .entry_present (out_chan.entry_present),
  .entry_write   (out_chan.entry_write),
  .entry_user    (out_chan.entry_user),
  .entry_frame   (out_chan.entry_frame)
);
